### rtl/kce_pkg.sv
// ----------------------------------------------------------------------------
// kce_pkg
// Shared types, key codes, LCD bytes and the banner text of the line editor.
// ----------------------------------------------------------------------------
package kce_pkg;

    // Defaults of the editor geometry and the key queue.
    localparam int DEF_ROW_CELLS   = 20;
    localparam int DEF_ROW_COUNT   = 3;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Column field wide enough for a row of up to 64 cells.
    localparam int COL_W = 6;

    // Keyboard codes.
    localparam logic [7:0] KEY_BKSP        = 8'h08;
    localparam logic [7:0] KEY_ENTER       = 8'h0A;
    localparam logic [7:0] KEY_SHIFT_MAKE  = 8'h0E;
    localparam logic [7:0] KEY_SHIFT_BREAK = 8'h8E;
    localparam logic [7:0] KEY_CAPS        = 8'h0F;
    localparam logic [7:0] KEY_PRINT_LO    = 8'h20;
    localparam logic [7:0] KEY_UPPER_A     = 8'h41;
    localparam logic [7:0] KEY_UPPER_Z     = 8'h5A;
    localparam logic [7:0] CASE_OFFSET     = 8'h20;

    // LCD bytes.
    localparam logic [7:0] LCD_CLEAR     = 8'h01;
    localparam logic [7:0] LCD_HOME_ADDR = 8'h80;
    localparam logic [7:0] LCD_BLANK     = 8'h20;

    // Register indexes of the configuration port.
    localparam logic [1:0] REG_ROW0 = 2'd0;
    localparam logic [1:0] REG_ROW1 = 2'd1;
    localparam logic [1:0] REG_ROW2 = 2'd2;

    localparam logic [7:0] ROW0_RESET = 8'hC0;
    localparam logic [7:0] ROW1_RESET = 8'h94;
    localparam logic [7:0] ROW2_RESET = 8'hD4;

    // Sequencer step counts.
    localparam int          BANNER_LEN      = 15;
    localparam logic [4:0]  STEP_BANNER_0   = 5'd2;
    localparam logic [4:0]  STEP_ENTER_LAST = 5'd17;
    localparam logic [4:0]  STEP_BKSP_LAST  = 5'd2;

    typedef enum logic [1:0] {
        KIND_CMD  = 2'd0,
        KIND_DATA = 2'd1,
        KIND_LED  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        OP_BKSP  = 2'd0,
        OP_ENTER = 2'd1,
        OP_LED   = 2'd2,
        OP_PRINT = 2'd3
    } t_op_kind;

    // One classified key, as queued between the front and the back.
    typedef struct packed {
        t_op_kind         op;
        logic [7:0]       ch;      // character to write (print)
        logic [1:0]       row;     // row of the address command
        logic [COL_W-1:0] col;     // column of the address command
        logic [1:0]       leds;    // bit0 caps, bit1 shift
        logic             follow;  // print: an address command follows
    } t_op_entry;

    function automatic logic [7:0] banner_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:    c = 8'h4B; // K
            4'd1:    c = 8'h65; // e
            4'd2:    c = 8'h79; // y
            4'd3:    c = 8'h62; // b
            4'd4:    c = 8'h6F; // o
            4'd5:    c = 8'h61; // a
            4'd6:    c = 8'h72; // r
            4'd7:    c = 8'h64; // d
            4'd8:    c = 8'h20; // space
            4'd9:    c = 8'h53; // S
            4'd10:   c = 8'h61; // a
            4'd11:   c = 8'h6D; // m
            4'd12:   c = 8'h70; // p
            4'd13:   c = 8'h6C; // l
            4'd14:   c = 8'h65; // e
            default: c = 8'h20;
        endcase
        return c;
    endfunction

endpackage

### rtl/keyboard_to_char_lcd_editor_top.sv
// ----------------------------------------------------------------------------
// keyboard_to_char_lcd_editor_top
// Keyboard codes in, character LCD writes and status LEDs out.
//
//   channel   direction  fields
//   s_axis    in         tdata[7:0] key_code
//   m_axis    out        tdata[7:0] lcd_byte, [9:8] led_bits; tuser kind; tlast last
//   cfg       in         i_cfg_idx 0..2 row address registers, i_cfg_wdata
//
// The front accepts one key per cycle while the four-entry key queue has room.
// The back sequencer emits one result per cycle while not stalled: Enter gives 18
// results, backspace 3, a printable key 1 or 2, a shift or caps key 1.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds the back, and the queue lets the front keep taking keys.
// ----------------------------------------------------------------------------
module keyboard_to_char_lcd_editor_top #(
    parameter int ROW_CELLS   = kce_pkg::DEF_ROW_CELLS,
    parameter int ROW_COUNT   = kce_pkg::DEF_ROW_COUNT,
    parameter int QUEUE_DEPTH = kce_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] key_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] lcd_byte, [9:8] led_bits, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata
);
    import kce_pkg::*;

    logic      w_push, w_q_ready, w_pop, w_head_valid;
    t_op_entry w_entry, w_head;
    t_kind     w_kind;
    logic [7:0] w_lcd_byte;
    logic [1:0] w_led_bits;

    kce_front #(
        .ROW_CELLS (ROW_CELLS),
        .ROW_COUNT (ROW_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_key_valid (s_axis_tvalid),
        .o_key_ready (s_axis_tready),
        .i_key_code  (s_axis_tdata),
        .o_push      (w_push),
        .o_entry     (w_entry),
        .i_q_ready   (w_q_ready)
    );

    kce_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .o_ready (w_q_ready),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    kce_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_head_valid (w_head_valid),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_kind       (w_kind),
        .o_lcd_byte   (w_lcd_byte),
        .o_led_bits   (w_led_bits),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, w_led_bits, w_lcd_byte};
    assign m_axis_tuser = w_kind;

endmodule

### rtl/kce_front.sv
// ----------------------------------------------------------------------------
// kce_front
// Accepts key codes, tracks cursor, caps and shift, and queues one
// classified operation per key that causes LCD writes or an LED update.
// ----------------------------------------------------------------------------
module kce_front #(
    parameter int ROW_CELLS = kce_pkg::DEF_ROW_CELLS,
    parameter int ROW_COUNT = kce_pkg::DEF_ROW_COUNT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_key_valid,
    output logic                o_key_ready,
    input  logic [7:0]          i_key_code,
    output logic                o_push,
    output kce_pkg::t_op_entry  o_entry,
    input  logic                i_q_ready
);
    import kce_pkg::*;

    localparam int CW = $clog2(ROW_CELLS * ROW_COUNT + 1);
    localparam logic [CW-1:0] CELL_LIMIT = CW'(ROW_CELLS * ROW_COUNT);
    localparam logic [CW:0]   ROW1_START = (CW + 1)'(ROW_CELLS);
    localparam logic [CW:0]   ROW2_START = (CW + 1)'(2 * ROW_CELLS);

    logic [CW-1:0] r_cursor, n_cursor;
    logic          r_caps, n_caps;
    logic          r_shift, n_shift;

    logic          w_accept;
    logic [CW-1:0] w_pos;
    logic [CW:0]   w_pos_ext;
    logic [1:0]    w_row;
    logic [CW:0]   w_row_start;
    logic [7:0]    w_char;

    assign o_key_ready = i_q_ready;
    assign w_accept    = i_key_valid & i_q_ready;

    // Lower-case letters unless exactly one of caps and shift is set.
    always_comb begin
        w_char = i_key_code;
        if (i_key_code >= KEY_UPPER_A && i_key_code <= KEY_UPPER_Z && !(r_caps ^ r_shift)) begin
            w_char = i_key_code + CASE_OFFSET;
        end
    end

    // Row and column of the cell whose address command is queued.
    always_comb begin
        w_pos_ext = (CW + 1)'(w_pos);
        if (w_pos_ext >= ROW2_START) begin
            w_row       = 2'd2;
            w_row_start = ROW2_START;
        end else if (w_pos_ext >= ROW1_START) begin
            w_row       = 2'd1;
            w_row_start = ROW1_START;
        end else begin
            w_row       = 2'd0;
            w_row_start = '0;
        end
    end

    always_comb begin
        n_cursor = r_cursor;
        n_caps   = r_caps;
        n_shift  = r_shift;
        o_push   = 1'b0;
        w_pos    = '0;
        o_entry.op = OP_LED;
        priority if (i_key_code == KEY_BKSP) begin
            o_entry.op = OP_BKSP;
            w_pos      = r_cursor - CW'(1);
            if (r_cursor != '0) begin
                o_push   = w_accept;
                n_cursor = w_pos;
            end
        end else if (i_key_code == KEY_ENTER) begin
            o_entry.op = OP_ENTER;
            o_push     = w_accept;
            n_cursor   = '0;
        end else if (i_key_code == KEY_SHIFT_MAKE) begin
            o_push  = w_accept;
            n_shift = 1'b1;
        end else if (i_key_code == KEY_SHIFT_BREAK) begin
            o_push  = w_accept;
            n_shift = 1'b0;
        end else if (i_key_code == KEY_CAPS) begin
            o_push = w_accept;
            n_caps = ~r_caps;
        end else if (!i_key_code[7] && i_key_code >= KEY_PRINT_LO) begin
            o_entry.op = OP_PRINT;
            w_pos      = r_cursor + CW'(1);
            if (r_cursor < CELL_LIMIT) begin
                o_push   = w_accept;
                n_cursor = w_pos;
            end
        end else begin
            o_push = 1'b0;
        end
        if (!w_accept) begin
            n_cursor = r_cursor;
            n_caps   = r_caps;
            n_shift  = r_shift;
        end
        o_entry.ch     = w_char;
        o_entry.row    = w_row;
        o_entry.col    = COL_W'(w_pos_ext - w_row_start);
        o_entry.leds   = {n_shift, n_caps};
        o_entry.follow = (w_pos < CELL_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_caps   <= 1'b0;
            r_shift  <= 1'b0;
        end else begin
            r_cursor <= n_cursor;
            r_caps   <= n_caps;
            r_shift  <= n_shift;
        end
    end

endmodule

### rtl/kce_fifo.sv
// ----------------------------------------------------------------------------
// kce_fifo
// Short register queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module kce_fifo #(
    parameter int DEPTH = kce_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  kce_pkg::t_op_entry  i_entry,
    output logic                o_ready,
    input  logic                i_pop,
    output logic                o_valid,
    output kce_pkg::t_op_entry  o_head
);
    import kce_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

    t_op_entry       r_mem [DEPTH];
    logic [PW-1:0]   r_wr, n_wr;
    logic [PW-1:0]   r_rd, n_rd;
    logic [CNTW-1:0] r_count, n_count;
    logic            w_push, w_pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push & o_ready;
    assign w_pop   = i_pop & o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + PW'(1);
        end
        if (w_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + PW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CNTW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

### rtl/kce_back.sv
// ----------------------------------------------------------------------------
// kce_back
// Steps through each queued operation and emits one LCD write or LED update per cycle,
// while not stalled, into a registered output stage. Holds the row address registers.
// ----------------------------------------------------------------------------
module kce_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [7:0]          i_cfg_wdata,
    input  logic                i_head_valid,
    input  kce_pkg::t_op_entry  i_head,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output kce_pkg::t_kind      o_kind,
    output logic [7:0]          o_lcd_byte,
    output logic [1:0]          o_led_bits,
    output logic                o_last
);
    import kce_pkg::*;

    logic [7:0] r_row_addr [3];
    logic [4:0] r_step, n_step;
    logic       r_out_valid;
    t_kind      r_kind, n_kind;
    logic [7:0] r_byte, n_byte;
    logic [1:0] r_leds;
    logic       r_last, n_last;

    logic       w_load;
    logic [7:0] w_base;
    logic [7:0] w_addr;
    logic [4:0] w_last_step;

    assign w_load = i_head_valid & (~r_out_valid | i_ready);
    assign o_pop  = w_load & (r_step == w_last_step);

    always_comb begin
        unique case (i_head.row)
            2'd0:    w_base = r_row_addr[0];
            2'd1:    w_base = r_row_addr[1];
            default: w_base = r_row_addr[2];
        endcase
        w_addr = w_base + 8'(i_head.col);
    end

    always_comb begin
        unique case (i_head.op)
            OP_BKSP:  w_last_step = STEP_BKSP_LAST;
            OP_ENTER: w_last_step = STEP_ENTER_LAST;
            OP_LED:   w_last_step = 5'd0;
            OP_PRINT: w_last_step = {4'd0, i_head.follow};
            default:  w_last_step = 5'd0;
        endcase
    end

    always_comb begin
        n_kind = KIND_LED;
        n_byte = 8'h00;
        unique case (i_head.op)
            OP_BKSP: begin
                if (r_step == 5'd1) begin
                    n_kind = KIND_DATA;
                    n_byte = LCD_BLANK;
                end else begin
                    n_kind = KIND_CMD;
                    n_byte = w_addr;
                end
            end
            OP_ENTER: begin
                if (r_step == 5'd0) begin
                    n_kind = KIND_CMD;
                    n_byte = LCD_CLEAR;
                end else if (r_step == 5'd1) begin
                    n_kind = KIND_CMD;
                    n_byte = LCD_HOME_ADDR;
                end else if (r_step == STEP_ENTER_LAST) begin
                    n_kind = KIND_CMD;
                    n_byte = w_addr;
                end else begin
                    n_kind = KIND_DATA;
                    n_byte = banner_char(4'(r_step - STEP_BANNER_0));
                end
            end
            OP_LED: begin
                n_kind = KIND_LED;
                n_byte = 8'h00;
            end
            OP_PRINT: begin
                if (r_step == 5'd0) begin
                    n_kind = KIND_DATA;
                    n_byte = i_head.ch;
                end else begin
                    n_kind = KIND_CMD;
                    n_byte = w_addr;
                end
            end
            default: begin
                n_kind = KIND_LED;
                n_byte = 8'h00;
            end
        endcase
        n_last = (r_step == w_last_step);
        n_step = r_step;
        if (w_load) begin
            n_step = n_last ? 5'd0 : r_step + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_addr[0] <= ROW0_RESET;
            r_row_addr[1] <= ROW1_RESET;
            r_row_addr[2] <= ROW2_RESET;
        end else if (i_cfg_we) begin
            priority if (i_cfg_idx == REG_ROW0) begin
                r_row_addr[0] <= i_cfg_wdata;
            end else if (i_cfg_idx == REG_ROW1) begin
                r_row_addr[1] <= i_cfg_wdata;
            end else if (i_cfg_idx == REG_ROW2) begin
                r_row_addr[2] <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= 5'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_leds <= i_head.leds;
            r_last <= n_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_kind     = r_kind;
    assign o_lcd_byte = r_byte;
    assign o_led_bits = r_leds;
    assign o_last     = r_last;

`ifndef SYNTHESIS
    a_step_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step <= STEP_ENTER_LAST)
        else $error("sequencer step out of range");

    a_mid_op_head : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 5'd0 |-> i_head_valid)
        else $error("operation in progress without a queued head");

    a_led_single : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kind == KIND_LED |-> r_last && r_byte == 8'h00)
        else $error("LED update must be a single zero-byte result");

    a_pop_resets : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_step == 5'd0)
        else $error("step not cleared after finishing an operation");
`endif

endmodule

### test/tb_keyboard_to_char_lcd_editor_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyboard_to_char_lcd_editor_top
// Self-checking bench for the keyboard line editor. Keys go in on the slave
// stream and every LCD or LED write that comes out is checked against a
// predictor of the editor: cursor, caps and shift state, and the three row
// address registers. The run covers directed corner keys, random typing with
// backspace, Enter and mode keys, a fill of the whole editor, and several
// row address settings, most of them under random stalls on both streams.
// ----------------------------------------------------------------------------
import kce_pkg::*;

localparam int         ROW_CELLS      = DEF_ROW_CELLS;
localparam int         ROW_COUNT      = DEF_ROW_COUNT;
localparam int         CELL_LIMIT     = ROW_CELLS * ROW_COUNT;
localparam logic [7:0] KEY_PRINT_END  = 8'h80;
localparam logic [1:0] REG_NONE       = 2'd3;
localparam string      BANNER_TEXT    = "Keyboard Sample";

typedef struct {
    t_kind      kind;
    logic [7:0] lcd_val;
    logic [1:0] leds;
    logic       last;
} t_lcd_write;

class lcd_editor_scoreboard;
    logic [7:0]  row_base [3];
    int unsigned cursor;
    logic        caps_on;
    logic        shift_held;
    t_lcd_write  pending_writes [$];
    int          errors;
    int          full_hits;

    function new();
        row_base[0] = ROW0_RESET;
        row_base[1] = ROW1_RESET;
        row_base[2] = ROW2_RESET;
        cursor      = 0;
        caps_on     = 1'b0;
        shift_held  = 1'b0;
        errors      = 0;
        full_hits   = 0;
    endfunction

    function void set_row(logic [1:0] idx, logic [7:0] val);
        if (idx != REG_NONE)
            row_base[idx] = val;
    endfunction

    function int pending();
        return pending_writes.size();
    endfunction

    function logic [7:0] cell_addr(int unsigned pos);
        int unsigned row;
        int unsigned col;
        row = pos / ROW_CELLS;
        col = pos % ROW_CELLS;
        if (row > ROW_COUNT - 1)
            row = ROW_COUNT - 1;
        return row_base[row] + 8'(col);
    endfunction

    function void push(t_kind kind, logic [7:0] val);
        t_lcd_write w;
        w.kind    = kind;
        w.lcd_val = val;
        w.leds    = {shift_held, caps_on};
        w.last    = 1'b0;
        pending_writes.push_back(w);
    endfunction

    function void note_key(logic [7:0] key);
        int         first;
        logic [7:0] ch;
        first = pending_writes.size();
        ch    = key;
        if (key == KEY_BKSP) begin
            if (cursor > 0) begin
                cursor--;
                push(KIND_CMD, cell_addr(cursor));
                push(KIND_DATA, LCD_BLANK);
                push(KIND_CMD, cell_addr(cursor));
            end
        end else if (key == KEY_ENTER) begin
            push(KIND_CMD, LCD_CLEAR);
            push(KIND_CMD, LCD_HOME_ADDR);
            for (int i = 0; i < BANNER_TEXT.len(); i++)
                push(KIND_DATA, BANNER_TEXT[i]);
            cursor = 0;
            push(KIND_CMD, cell_addr(0));
        end else if (key == KEY_SHIFT_MAKE) begin
            shift_held = 1'b1;
            push(KIND_LED, 8'h00);
        end else if (key == KEY_SHIFT_BREAK) begin
            shift_held = 1'b0;
            push(KIND_LED, 8'h00);
        end else if (key == KEY_CAPS) begin
            caps_on = ~caps_on;
            push(KIND_LED, 8'h00);
        end else if (key >= KEY_PRINT_LO && key < KEY_PRINT_END) begin
            // Letters come out lower case unless exactly one of caps and shift is set.
            if (key >= KEY_UPPER_A && key <= KEY_UPPER_Z && !(caps_on ^ shift_held))
                ch = key + CASE_OFFSET;
            if (cursor < CELL_LIMIT) begin
                push(KIND_DATA, ch);
                cursor++;
                if (cursor < CELL_LIMIT)
                    push(KIND_CMD, cell_addr(cursor));
            end else begin
                full_hits++;
            end
        end
        if (pending_writes.size() > first)
            pending_writes[pending_writes.size() - 1].last = 1'b1;
    endfunction

    task report(string what);
        $display("MISMATCH at %0t: %s", $time, what);
        errors++;
    endtask

    task check_result(logic [1:0] kind, logic [15:0] data, logic last);
        t_lcd_write w;
        if (pending_writes.size() == 0) begin
            report($sformatf("unexpected result kind %0d byte %02h", kind, data[7:0]));
            return;
        end
        w = pending_writes.pop_front();
        if (kind !== w.kind)
            report($sformatf("kind %0d, expected %0d", kind, w.kind));
        if (data[7:0] !== w.lcd_val)
            report($sformatf("lcd byte %02h, expected %02h", data[7:0], w.lcd_val));
        if (data[9:8] !== w.leds)
            report($sformatf("leds %b, expected %b", data[9:8], w.leds));
        if (data[15:10] !== 6'd0)
            report($sformatf("pad bits %b, expected zero", data[15:10]));
        if (last !== w.last)
            report($sformatf("last %b, expected %b", last, w.last));
    endtask
endclass

module tb_keyboard_to_char_lcd_editor_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int N_DIRECTED     = 24;
    localparam int N_PHASES       = 5;
    localparam int PHASE_KEYS     = 11;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [7:0]  i_cfg_wdata;

    lcd_editor_scoreboard sb;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int idle_cycles;
    int keys_taken;
    int results_seen;
    int reg_writes;

    keyboard_to_char_lcd_editor_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Monitor and watchdog: both streams are sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_key(s_axis_tdata);
                keys_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
                results_seen++;
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off while hold_left runs down.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready = 1'b0;
            hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [7:0] random_printable();
        return 8'($urandom_range(KEY_PRINT_LO, KEY_PRINT_END - 1));
    endfunction

    function automatic logic [7:0] random_key();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 30)
            return 8'($urandom_range(KEY_UPPER_A, KEY_UPPER_Z));
        else if (pick < 62)
            return random_printable();
        else if (pick < 70)
            return KEY_BKSP;
        else if (pick < 74)
            return KEY_ENTER;
        else if (pick < 78)
            return KEY_SHIFT_MAKE;
        else if (pick < 82)
            return KEY_SHIFT_BREAK;
        else if (pick < 86)
            return KEY_CAPS;
        else
            return 8'($urandom_range(255));
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    // Valid stays high for a following key unless the sender idles first.
    task automatic send_key(logic [7:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = key;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        // Then stay idle so that any stray output would still be caught.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] val);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        sb.set_row(idx, val);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Enter, then type past the last cell, back up once and refill.
    task automatic fill_editor();
        send_key(KEY_ENTER);
        repeat (CELL_LIMIT + 2) send_key(random_printable());
        send_key(KEY_BKSP);
        send_key(random_printable());
        send_key(random_printable());
    endtask

    initial begin
        logic [7:0] directed_keys [N_DIRECTED];
        logic [7:0] row_set [N_PHASES][3];

        sb            = new();
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = REG_ROW0;
        i_cfg_wdata   = 8'h00;
        hold_left     = 0;
        idle_cycles   = 0;
        keys_taken    = 0;
        results_seen  = 0;
        reg_writes    = 0;
        send_idle_pct = 15;
        recv_idle_pct = 78;

        directed_keys = '{
            KEY_ENTER, KEY_BKSP,
            8'h41, 8'h5A, 8'h40, 8'h5B, KEY_PRINT_LO, 8'h7F, 8'h61, 8'h7A,
            KEY_CAPS, 8'h41, KEY_SHIFT_MAKE, 8'h41, KEY_CAPS, 8'h5A,
            KEY_SHIFT_BREAK, KEY_BKSP,
            8'h00, 8'hFF, 8'h80, 8'h1F, 8'h09, 8'h8F
        };
        row_set[0] = '{8'h80, 8'h80, 8'h80};
        row_set[1] = '{8'hFF, 8'hFF, 8'hFF};
        row_set[2] = '{8'($urandom_range(128, 255)), 8'($urandom_range(128, 255)),
                       8'($urandom_range(128, 255))};
        row_set[3] = '{8'h00, 8'h7F, 8'($urandom_range(255))};
        row_set[4] = '{ROW0_RESET, ROW1_RESET, ROW2_RESET};

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_keys[k])
            send_key(directed_keys[k]);

        for (int p = 0; p < N_PHASES; p++) begin
            wait_drained();
            write_reg(REG_ROW0, row_set[p][0]);
            write_reg(REG_ROW1, row_set[p][1]);
            write_reg(REG_ROW2, row_set[p][2]);
            if (p == 0)
                write_reg(REG_NONE, 8'h55);
            if (p == 2) begin
                send_idle_pct = 78;
                recv_idle_pct = 15;
            end else if (p == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // The output stalls for a long stretch while keys keep coming.
            if (p == 1)
                hold_left = HOLD_CYCLES;
            if (p == 2 || p == 4)
                fill_editor();
            repeat (PHASE_KEYS) send_key(random_key());
        end

        wait_drained();
        $display("Covered %0d keys and %0d LCD/LED results across %0d register writes.",
                 keys_taken, results_seen, reg_writes);
        $display("Keys typed into a full editor: %0d; mismatches: %0d.",
                 sb.full_hits, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
rtl/kce_pkg.sv
rtl/kce_front.sv
rtl/kce_fifo.sv
rtl/kce_back.sv
rtl/keyboard_to_char_lcd_editor_top.sv
test/tb_keyboard_to_char_lcd_editor_top.sv
